[rtl/hsc_pkg.sv]
// hsc_pkg: shared types, constants and lookup functions for the two-set
// hangul syllable composer. No dependencies.
`default_nettype none

package hsc_pkg;

    // composer stages
    localparam logic [2:0] STAGE_START   = 3'd0;
    localparam logic [2:0] STAGE_INITIAL = 3'd1;
    localparam logic [2:0] STAGE_VOWEL   = 3'd2;
    localparam logic [2:0] STAGE_CVOWEL  = 3'd3;
    localparam logic [2:0] STAGE_FINAL   = 3'd4;
    localparam logic [2:0] STAGE_CFINAL  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_PREEDIT = 2'd0;
    localparam logic [1:0] KIND_COMMIT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    localparam logic [15:0] FILL_CODE = 16'h8441;

    localparam logic [7:0] CONS_FIRST  = 8'h82;
    localparam logic [7:0] CONS_LAST   = 8'h94;
    localparam logic [7:0] VOWEL_FIRST = 8'hA3;
    localparam logic [7:0] VOWEL_LAST  = 8'hBD;

    // consonants that never stand as a final
    localparam logic [7:0] KEY_NO_FINAL_A = 8'h86;
    localparam logic [7:0] KEY_NO_FINAL_B = 8'h8A;
    localparam logic [7:0] KEY_NO_FINAL_C = 8'h8F;

    typedef struct packed {
        logic [2:0]  stage;
        logic [15:0] cur_code;
        logic [7:0]  last_key;
        logic [15:0] code_before_final;
    } comp_state_t;

    typedef struct packed {
        logic        reject;
        logic        commit;
        logic [15:0] commit_code;
    } step_info_t;

    function automatic logic key_in_range(input logic [7:0] key);
        key_in_range = ((key >= CONS_FIRST) && (key <= CONS_LAST)) ||
                       ((key >= VOWEL_FIRST) && (key <= VOWEL_LAST));
    endfunction

    // {hit, medial field}
    function automatic logic [5:0] vowel_pair(input logic [7:0] prev, input logic [7:0] key);
        case ({prev, key})
            16'hADA3: vowel_pair = {1'b1, 5'h0E};
            16'hADA4: vowel_pair = {1'b1, 5'h0F};
            16'hADBD: vowel_pair = {1'b1, 5'h12};
            16'hB4A7: vowel_pair = {1'b1, 5'h15};
            16'hB4AA: vowel_pair = {1'b1, 5'h16};
            16'hB4BD: vowel_pair = {1'b1, 5'h17};
            16'hBBBD: vowel_pair = {1'b1, 5'h1C};
            default:  vowel_pair = 6'd0;
        endcase
    endfunction

    // {hit, final field}
    function automatic logic [5:0] final_pair(input logic [7:0] prev, input logic [7:0] key);
        case ({prev, key})
            16'h828B: final_pair = {1'b1, 5'd4};
            16'h848E: final_pair = {1'b1, 5'd6};
            16'h8494: final_pair = {1'b1, 5'd7};
            16'h8782: final_pair = {1'b1, 5'd10};
            16'h8788: final_pair = {1'b1, 5'd11};
            16'h8789: final_pair = {1'b1, 5'd12};
            16'h878B: final_pair = {1'b1, 5'd13};
            16'h8792: final_pair = {1'b1, 5'd14};
            16'h8793: final_pair = {1'b1, 5'd15};
            16'h8794: final_pair = {1'b1, 5'd16};
            16'h898B: final_pair = {1'b1, 5'd20};
            default:  final_pair = 6'd0;
        endcase
    endfunction

    // final field for a consonant key
    function automatic logic [4:0] final_of_key(input logic [7:0] key);
        case (key)
            8'h82:   final_of_key = 5'd2;
            8'h83:   final_of_key = 5'd3;
            8'h84:   final_of_key = 5'd5;
            8'h85:   final_of_key = 5'd8;
            8'h87:   final_of_key = 5'd9;
            8'h88:   final_of_key = 5'd17;
            8'h89:   final_of_key = 5'd19;
            8'h8B:   final_of_key = 5'd21;
            8'h8C:   final_of_key = 5'd22;
            8'h8D:   final_of_key = 5'd23;
            8'h8E:   final_of_key = 5'd24;
            8'h90:   final_of_key = 5'd25;
            8'h91:   final_of_key = 5'd26;
            8'h92:   final_of_key = 5'd27;
            8'h93:   final_of_key = 5'd28;
            8'h94:   final_of_key = 5'd29;
            default: final_of_key = 5'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/hsc_compose.sv]
// hsc_compose: next-state logic of the syllable automaton for one key,
// including commit and replay of leftover keys. Depends on hsc_pkg.
`default_nettype none

module hsc_compose (
    input  wire logic [7:0]          key,
    input  wire hsc_pkg::comp_state_t state_cur,
    output hsc_pkg::comp_state_t      state_nxt,
    output hsc_pkg::step_info_t       info
);

    logic        key_ok;
    logic        vowel;
    logic        can_final;
    logic [2:0]  st_eff;
    logic [7:0]  prev;
    logic [5:0]  vp;
    logic [5:0]  fp;
    logic [15:0] start_code;
    logic [15:0] carry_code;
    logic        extend;
    logic        handoff;
    logic [2:0]  ext_stage;
    logic [15:0] ext_code;

    always_comb begin
        key_ok    = hsc_pkg::key_in_range(key);
        vowel     = (key[6:5] == 2'b01);
        can_final = !vowel && (key != hsc_pkg::KEY_NO_FINAL_A) &&
                    (key != hsc_pkg::KEY_NO_FINAL_B) && (key != hsc_pkg::KEY_NO_FINAL_C);
        if ((state_cur.stage >= hsc_pkg::STAGE_INITIAL) &&
            (state_cur.stage <= hsc_pkg::STAGE_CFINAL)) begin
            st_eff = state_cur.stage;
        end else begin
            st_eff = hsc_pkg::STAGE_START;
        end
        prev = (st_eff == hsc_pkg::STAGE_START) ? 8'd0 : state_cur.last_key;
        vp   = hsc_pkg::vowel_pair(prev, key);
        fp   = hsc_pkg::final_pair(prev, key);

        // key placed into a fresh fill syllable
        if (vowel) begin
            start_code = {hsc_pkg::FILL_CODE[15:10], key[4:0], hsc_pkg::FILL_CODE[4:0]};
        end else begin
            start_code = {hsc_pkg::FILL_CODE[15], key[4:0], hsc_pkg::FILL_CODE[9:0]};
        end
        // previous final consonant moved to the initial of a fresh syllable
        carry_code = {hsc_pkg::FILL_CODE[15], state_cur.last_key[4:0],
                      hsc_pkg::FILL_CODE[9:0]};

        extend    = 1'b0;
        handoff   = 1'b0;
        ext_stage = hsc_pkg::STAGE_START;
        ext_code  = state_cur.cur_code;

        case (st_eff)
            hsc_pkg::STAGE_INITIAL: begin
                if (vowel) begin
                    extend    = 1'b1;
                    ext_stage = hsc_pkg::STAGE_VOWEL;
                    ext_code  = {state_cur.cur_code[15:10], key[4:0], state_cur.cur_code[4:0]};
                end
            end
            hsc_pkg::STAGE_VOWEL: begin
                if (can_final) begin
                    extend    = 1'b1;
                    ext_stage = hsc_pkg::STAGE_FINAL;
                    ext_code  = {state_cur.cur_code[15:5], hsc_pkg::final_of_key(key)};
                end else if (vp[5]) begin
                    extend    = 1'b1;
                    ext_stage = hsc_pkg::STAGE_CVOWEL;
                    ext_code  = {state_cur.cur_code[15:10], vp[4:0], state_cur.cur_code[4:0]};
                end
            end
            hsc_pkg::STAGE_CVOWEL: begin
                if (can_final) begin
                    extend    = 1'b1;
                    ext_stage = hsc_pkg::STAGE_FINAL;
                    ext_code  = {state_cur.cur_code[15:5], hsc_pkg::final_of_key(key)};
                end
            end
            hsc_pkg::STAGE_FINAL: begin
                if (!vowel && fp[5]) begin
                    extend    = 1'b1;
                    ext_stage = hsc_pkg::STAGE_CFINAL;
                    ext_code  = {state_cur.cur_code[15:5], fp[4:0]};
                end else if (vowel) begin
                    handoff = 1'b1;
                end
            end
            hsc_pkg::STAGE_CFINAL: begin
                handoff = vowel;
            end
            default: begin
                extend    = 1'b1;
                ext_stage = vowel ? hsc_pkg::STAGE_VOWEL : hsc_pkg::STAGE_INITIAL;
                ext_code  = start_code;
            end
        endcase

        state_nxt = state_cur;
        if (key_ok) begin
            state_nxt.last_key = key;
            if (extend) begin
                state_nxt.stage             = ext_stage;
                state_nxt.cur_code          = ext_code;
                state_nxt.code_before_final = (st_eff == hsc_pkg::STAGE_START) ?
                                              hsc_pkg::FILL_CODE : state_cur.cur_code;
            end else if (handoff) begin
                state_nxt.stage             = hsc_pkg::STAGE_VOWEL;
                state_nxt.cur_code          = {carry_code[15:10], key[4:0], carry_code[4:0]};
                state_nxt.code_before_final = carry_code;
            end else begin
                state_nxt.stage             = vowel ? hsc_pkg::STAGE_VOWEL :
                                                      hsc_pkg::STAGE_INITIAL;
                state_nxt.cur_code          = start_code;
                state_nxt.code_before_final = hsc_pkg::FILL_CODE;
            end
        end

        info.reject      = !key_ok;
        info.commit      = key_ok && !extend;
        info.commit_code = handoff ? state_cur.code_before_final : state_cur.cur_code;
    end

endmodule

`default_nettype wire

[rtl/hangul_two_set_syllable_composer_unit.sv]
// hangul_two_set_syllable_composer_unit: top level with key register, automaton
// state and result register. Depends on hsc_pkg and hsc_compose.
//
//   channel   ports                                       direction
//   input     s_valid s_ready s_key_code                  key in
//   result    m_valid m_ready m_kind m_syllable m_last_of_run  results out
//
// the result register loads straight from the key register; a key giving only a
// preedit (or a reject) leaves as its one result loads, a key that commits stays
// for a second load because its two results share the one result register
// aresetn is synchronous, active low: stage start, fill syllable, no results held
// a stalled result register holds the key register; a new key is still taken
// in the cycle the held key leaves
`default_nettype none

module hangul_two_set_syllable_composer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_key_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_syllable,
    output logic             m_last_of_run
);

    logic                 key_valid_reg;
    logic [7:0]           key_reg;
    logic                 phase_reg;
    hsc_pkg::comp_state_t state_reg;
    hsc_pkg::comp_state_t state_next;
    hsc_pkg::step_info_t  info;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_syl_reg;
    logic        out_last_reg;
    logic [1:0]  out_kind_next;
    logic [15:0] out_syl_next;
    logic        out_last_next;

    logic out_load;
    logic finish;

    hsc_compose u_compose (
        .key       (key_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .info      (info)
    );

    assign out_load = key_valid_reg && (!out_valid_reg || m_ready);
    // the key leaves once its last result is loaded
    assign finish   = out_load && (phase_reg || !info.commit);
    assign s_ready  = !key_valid_reg || finish;

    always_comb begin
        if (info.reject) begin
            out_kind_next = hsc_pkg::KIND_REJECT;
            out_syl_next  = 16'd0;
            out_last_next = 1'b1;
        end else if (info.commit && !phase_reg) begin
            out_kind_next = hsc_pkg::KIND_COMMIT;
            out_syl_next  = info.commit_code;
            out_last_next = 1'b0;
        end else begin
            out_kind_next = hsc_pkg::KIND_PREEDIT;
            out_syl_next  = state_next.cur_code;
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{stage: hsc_pkg::STAGE_START, cur_code: hsc_pkg::FILL_CODE,
                               last_key: 8'd0, code_before_final: hsc_pkg::FILL_CODE};
        end else begin
            if (s_valid && s_ready) begin
                key_valid_reg <= 1'b1;
            end else if (finish) begin
                key_valid_reg <= 1'b0;
            end
            if (out_load) begin
                phase_reg <= !phase_reg && info.commit;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (finish) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg <= s_key_code;
        end
        if (out_load) begin
            out_kind_reg <= out_kind_next;
            out_syl_reg  <= out_syl_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_syllable    = out_syl_reg;
    assign m_last_of_run = out_last_reg;

endmodule

`default_nettype wire

[tb/hangul_two_set_syllable_composer_unit_tb.sv]
// hangul_two_set_syllable_composer_unit_tb: self-checking bench for the two-set hangul
// syllable composer; predicts commit/preedit/reject results per key and compares them.
// Depends on hsc_pkg and the hangul_two_set_syllable_composer_unit rtl.
`default_nettype none

module hangul_two_set_syllable_composer_unit_tb;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TOTAL_KEYS   = 1850;

    // outcomes of one step of the predicted automaton
    localparam int EXT_GROWN    = 0;
    localparam int EXT_ENDS     = 1;
    localparam int EXT_HANDS_ON = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] syllable;
        logic        last_of_run;
    } key_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_key_code;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [15:0] m_syllable;
    logic        m_last_of_run;

    // predicted composer state
    logic [2:0]  comp_stage;
    logic [15:0] comp_code;
    logic [7:0]  comp_last_key;
    logic [15:0] comp_code_before_final;

    key_result_t pending_results[$];
    key_result_t oldest_result;
    int          mismatches;
    int          keys_sent;
    int          stall_cycles;
    logic        no_idle;

    hangul_two_set_syllable_composer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key_code    (s_key_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_syllable    (m_syllable),
        .m_last_of_run (m_last_of_run)
    );

    always #6 aclk = ~aclk;

    // {first key, second key, combined key}
    function automatic logic [23:0] vowel_combo(input int i);
        case (i)
            0: vowel_combo = 24'hADA3AE;
            1: vowel_combo = 24'hADA4AF;
            2: vowel_combo = 24'hADBDB2;
            3: vowel_combo = 24'hB4A7B5;
            4: vowel_combo = 24'hB4AAB6;
            5: vowel_combo = 24'hB4BDB7;
            6: vowel_combo = 24'hBBBDBC;
            default: vowel_combo = 24'h0;
        endcase
    endfunction

    function automatic logic [23:0] final_combo(input int i);
        case (i)
            0:  final_combo = 24'h828BC4;
            1:  final_combo = 24'h848EC6;
            2:  final_combo = 24'h8494C7;
            3:  final_combo = 24'h8782CA;
            4:  final_combo = 24'h8788CB;
            5:  final_combo = 24'h8789CC;
            6:  final_combo = 24'h878BCD;
            7:  final_combo = 24'h8792CE;
            8:  final_combo = 24'h8793CF;
            9:  final_combo = 24'h8794D0;
            10: final_combo = 24'h898BD4;
            default: final_combo = 24'h0;
        endcase
    endfunction

    // consonant key offset from 0x82 to its final-consonant key
    function automatic logic [7:0] final_key_of_initial(input logic [7:0] idx);
        case (idx)
            8'd0:  final_key_of_initial = 8'hC2;
            8'd1:  final_key_of_initial = 8'hC3;
            8'd2:  final_key_of_initial = 8'hC5;
            8'd3:  final_key_of_initial = 8'hC8;
            8'd5:  final_key_of_initial = 8'hC9;
            8'd6:  final_key_of_initial = 8'hD1;
            8'd7:  final_key_of_initial = 8'hD3;
            8'd9:  final_key_of_initial = 8'hD5;
            8'd10: final_key_of_initial = 8'hD6;
            8'd11: final_key_of_initial = 8'hD7;
            8'd12: final_key_of_initial = 8'hD8;
            8'd14: final_key_of_initial = 8'hD9;
            8'd15: final_key_of_initial = 8'hDA;
            8'd16: final_key_of_initial = 8'hDB;
            8'd17: final_key_of_initial = 8'hDC;
            8'd18: final_key_of_initial = 8'hDD;
            default: final_key_of_initial = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] lookup_vowel_combo(input logic [7:0] prev,
                                                      input logic [7:0] key);
        logic [23:0] c;
        for (int i = 0; i < 7; i++) begin
            c = vowel_combo(i);
            if (c[23:16] == prev && c[15:8] == key) return c[7:0];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] lookup_final_combo(input logic [7:0] prev,
                                                      input logic [7:0] key);
        logic [23:0] c;
        for (int i = 0; i < 11; i++) begin
            c = final_combo(i);
            if (c[23:16] == prev && c[15:8] == key) return c[7:0];
        end
        return 8'h00;
    endfunction

    function automatic logic key_accepted_range(input logic [7:0] key);
        return ((key >= hsc_pkg::CONS_FIRST) && (key <= hsc_pkg::CONS_LAST)) ||
               ((key >= hsc_pkg::VOWEL_FIRST) && (key <= hsc_pkg::VOWEL_LAST));
    endfunction

    // syllable extended, syllable ends, or ends and hands its last consonant on
    function automatic int extend_syllable(input logic [7:0] key);
        logic        is_vowel;
        logic        can_final;
        logic [2:0]  st;
        logic [2:0]  nxt;
        logic [15:0] code;
        logic [7:0]  prev;
        logic [7:0]  k;
        logic [7:0]  combo;
        logic [7:0]  diff;
        is_vowel  = (key[6:5] == 2'b01);
        can_final = !is_vowel && key != hsc_pkg::KEY_NO_FINAL_A &&
                    key != hsc_pkg::KEY_NO_FINAL_B && key != hsc_pkg::KEY_NO_FINAL_C;
        st   = (comp_stage >= hsc_pkg::STAGE_INITIAL && comp_stage <= hsc_pkg::STAGE_CFINAL) ?
               comp_stage : hsc_pkg::STAGE_START;
        code = (st != hsc_pkg::STAGE_START) ? comp_code : hsc_pkg::FILL_CODE;
        prev = (st != hsc_pkg::STAGE_START) ? comp_last_key : 8'h00;
        k    = key;
        nxt  = hsc_pkg::STAGE_START;
        case (st)
            hsc_pkg::STAGE_START: begin
                nxt = is_vowel ? hsc_pkg::STAGE_VOWEL : hsc_pkg::STAGE_INITIAL;
            end
            hsc_pkg::STAGE_INITIAL: begin
                if (!is_vowel) return EXT_ENDS;
                nxt = hsc_pkg::STAGE_VOWEL;
            end
            hsc_pkg::STAGE_VOWEL: begin
                combo = lookup_vowel_combo(prev, key);
                if (can_final) begin
                    nxt = hsc_pkg::STAGE_FINAL;
                end else if (combo != 8'h00) begin
                    k   = combo;
                    nxt = hsc_pkg::STAGE_CVOWEL;
                end else begin
                    return EXT_ENDS;
                end
            end
            hsc_pkg::STAGE_CVOWEL: begin
                if (!can_final) return EXT_ENDS;
                nxt = hsc_pkg::STAGE_FINAL;
            end
            hsc_pkg::STAGE_FINAL: begin
                if (is_vowel) return EXT_HANDS_ON;
                combo = lookup_final_combo(prev, key);
                if (combo == 8'h00) return EXT_ENDS;
                k   = combo;
                nxt = hsc_pkg::STAGE_CFINAL;
            end
            default: begin
                return is_vowel ? EXT_HANDS_ON : EXT_ENDS;
            end
        endcase

        case (nxt)
            hsc_pkg::STAGE_INITIAL: begin
                diff = k - 8'h80;
                code[14:10] = diff[4:0];
            end
            hsc_pkg::STAGE_VOWEL, hsc_pkg::STAGE_CVOWEL: begin
                diff = k - 8'hA0;
                code[9:5] = diff[4:0];
            end
            hsc_pkg::STAGE_FINAL: begin
                diff = k - 8'h82;
                k = (diff < 8'd19) ? final_key_of_initial(diff) : 8'hC0;
                diff = k - 8'hC0;
                code[4:0] = diff[4:0];
            end
            default: begin
                diff = k - 8'hC0;
                code[4:0] = diff[4:0];
            end
        endcase

        comp_code_before_final = (st != hsc_pkg::STAGE_START) ? comp_code : hsc_pkg::FILL_CODE;
        comp_code     = code;
        comp_last_key = key;
        comp_stage    = nxt;
        return EXT_GROWN;
    endfunction

    task automatic predict_results(input logic [7:0] key);
        int         outcome;
        logic [7:0] carried;
        if (!key_accepted_range(key)) begin
            pending_results.push_back('{hsc_pkg::KIND_REJECT, 16'h0000, 1'b1});
            return;
        end
        outcome = extend_syllable(key);
        if (outcome == EXT_ENDS) begin
            pending_results.push_back('{hsc_pkg::KIND_COMMIT, comp_code, 1'b0});
            comp_stage = hsc_pkg::STAGE_START;
            outcome = extend_syllable(key);
        end else if (outcome == EXT_HANDS_ON) begin
            // the final consonant moves over to start the next syllable
            carried = comp_last_key;
            pending_results.push_back('{hsc_pkg::KIND_COMMIT, comp_code_before_final, 1'b0});
            comp_stage = hsc_pkg::STAGE_START;
            outcome = extend_syllable(carried);
            outcome = extend_syllable(key);
        end
        pending_results.push_back('{hsc_pkg::KIND_PREEDIT, comp_code, 1'b1});
    endtask

    task automatic send_key(input logic [7:0] key);
        predict_results(key);
        keys_sent++;
        if (!no_idle) begin
            while ($urandom_range(99) < 12) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid    <= 1'b1;
        s_key_code <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_consonant();
        logic [7:0] key;
        key = 8'($urandom_range(hsc_pkg::CONS_LAST, hsc_pkg::CONS_FIRST));
        return key;
    endfunction

    function automatic logic [7:0] random_vowel();
        logic [7:0] key;
        key = 8'($urandom_range(hsc_pkg::VOWEL_LAST, hsc_pkg::VOWEL_FIRST));
        return key;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result channel: compare each transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %h syllable %h",
                         $time, m_kind, m_syllable);
                mismatches++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("kind", 16'(oldest_result.kind), 16'(m_kind));
                check_field("syllable", oldest_result.syllable, m_syllable);
                check_field("last_of_run", 16'(oldest_result.last_of_run),
                            16'(m_last_of_run));
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 12);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("hangul_two_set_syllable_composer_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic test_out_of_range_keys();
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h81);
        send_key(8'h95);
        send_key(8'hA2);
        send_key(8'hBE);
    endtask

    task automatic test_syllable_shapes();
        send_key(hsc_pkg::CONS_FIRST);       // initial
        send_key(hsc_pkg::CONS_LAST);        // consonant after initial commits
        send_key(hsc_pkg::VOWEL_FIRST);
        send_key(hsc_pkg::KEY_NO_FINAL_A);   // consonant that cannot close the syllable
        send_key(8'hAD);
        send_key(8'hA3);            // compound vowel
        send_key(8'h82);            // final
        send_key(8'hA5);            // vowel pulls the final into a new syllable
        send_key(8'h84);
        send_key(8'hFF);            // rejected mid-syllable, state kept
        send_key(8'h94);            // compound final
        send_key(hsc_pkg::VOWEL_LAST);       // vowel after compound final
        send_key(8'h83);
        send_key(8'hBB);
        send_key(8'hBD);
        send_key(8'hBD);            // vowel that does not combine
        send_key(hsc_pkg::KEY_NO_FINAL_C);
    endtask

    task automatic test_random_words(input int target);
        logic [23:0] c;
        int          pick;
        while (keys_sent < target) begin
            no_idle = (keys_sent >= 700 && keys_sent < 1000);
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_key(8'($urandom_range(255)));
            end else if (pick < 16) begin
                send_key($urandom_range(1) ? random_consonant() : random_vowel());
            end else begin
                if ($urandom_range(9) != 0) send_key(random_consonant());
                if ($urandom_range(2) == 0) begin
                    c = vowel_combo($urandom_range(6));
                    send_key(c[23:16]);
                    if ($urandom_range(3) != 0) send_key(c[15:8]);
                end else begin
                    send_key(random_vowel());
                end
                case ($urandom_range(3))
                    0: ;
                    3: begin
                        c = final_combo($urandom_range(10));
                        send_key(c[23:16]);
                        send_key(c[15:8]);
                    end
                    default: send_key(random_consonant());
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_key_code = 8'h00;
        no_idle    = 1'b0;
        keys_sent  = 0;
        comp_stage    = hsc_pkg::STAGE_START;
        comp_code     = hsc_pkg::FILL_CODE;
        comp_last_key = 8'h00;
        comp_code_before_final = hsc_pkg::FILL_CODE;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_out_of_range_keys();
        test_syllable_shapes();
        test_random_words(TOTAL_KEYS);
        wait_for_results();

        if (mismatches == 0)
            $display("hangul_two_set_syllable_composer_unit_tb: PASS");
        else
            $display("hangul_two_set_syllable_composer_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/hsc_pkg.sv
rtl/hsc_compose.sv
rtl/hangul_two_set_syllable_composer_unit.sv
tb/hangul_two_set_syllable_composer_unit_tb.sv
